// ===== rtl/sac_pkg.sv =====
// shared widths, types and codes for the swept box collision unit
package sac_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int SIZE_W    = 31;
  localparam int GAP_W     = 35;
  localparam int NUM_W     = GAP_W + FRAC_BITS;
  localparam int QW        = 33;
  localparam int REM_W     = 32;
  localparam int HI_W      = NUM_W - QW;
  localparam int T_W       = 32;
  localparam int ET_W      = 17;
  localparam int LANE_LAT  = QW + 2;
  localparam int NREG      = 6;
  localparam int IDX_W     = 3;

  localparam logic signed [T_W-1:0] TMAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] TMIN = {1'b1, {(T_W-1){1'b0}}};
  localparam logic signed [T_W-1:0] ONE  = T_W'(64'd1 << FRAC_BITS);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [IDX_W-1:0] REG_MSX = 3'd0;
  localparam logic [IDX_W-1:0] REG_MSY = 3'd1;
  localparam logic [IDX_W-1:0] REG_MSZ = 3'd2;
  localparam logic [IDX_W-1:0] REG_TSX = 3'd3;
  localparam logic [IDX_W-1:0] REG_TSY = 3'd4;
  localparam logic [IDX_W-1:0] REG_TSZ = 3'd5;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QW-1:0]    low;
    logic [QW-1:0]    q;
    logic [REM_W-1:0] ad;
    logic             neg;
    logic             ovf;
  } div_cell_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] pos;
    logic [2:0] zero;
  } side_t;

endpackage

// ===== rtl/sac_div_cell.sv =====
// one restoring division step, registered
module sac_div_cell import sac_pkg::*; (
  input  logic      clk,
  input  div_cell_t d,
  output div_cell_t q
);

  logic [REM_W:0] t;
  logic [REM_W:0] dext;
  logic [REM_W:0] diff;
  logic           ge;

  always_comb begin
    t    = {d.rem, d.low[QW-1]};
    dext = {1'b0, d.ad};
    diff = t - dext;
    ge   = (t >= dext);
  end

  always_ff @(posedge clk) begin
    q.rem <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
    q.low <= {d.low[QW-2:0], 1'b0};
    q.q   <= {d.q[QW-2:0], ge};
    q.ad  <= d.ad;
    q.neg <= d.neg;
    q.ovf <= d.ovf;
  end

endmodule

// ===== rtl/sac_div_lane.sv =====
// pipelined floor division of a gap by a velocity, saturated time out
module sac_div_lane import sac_pkg::*; (
  input  logic                    clk,
  input  logic signed [GAP_W-1:0] num,
  input  logic signed [POS_W-1:0] den,
  output logic signed [T_W-1:0]   quo
);

  div_cell_t        chain [0:QW];
  logic [GAP_W-1:0] an;
  logic [REM_W-1:0] ad;
  logic [NUM_W-1:0] n_mag;
  logic [QW:0]      m;

  always_comb begin
    an    = num[GAP_W-1] ? GAP_W'(-num) : GAP_W'(num);
    ad    = den[POS_W-1] ? REM_W'(-den) : REM_W'(den);
    n_mag = {an, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    chain[0].rem <= REM_W'(n_mag[NUM_W-1:QW]);
    chain[0].low <= n_mag[QW-1:0];
    chain[0].q   <= '0;
    chain[0].ad  <= ad;
    chain[0].neg <= num[GAP_W-1] ^ den[POS_W-1];
    // quotient would need more than QW bits
    chain[0].ovf <= (REM_W'(n_mag[NUM_W-1:QW]) >= ad);
  end

  for (genvar i = 0; i < QW; i++) begin : g_cell
    sac_div_cell u_cell (
      .clk (clk),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  assign m = {1'b0, chain[QW].q} + (QW+1)'(chain[QW].rem != '0);

  always_ff @(posedge clk) begin
    if (!chain[QW].neg) begin
      if (chain[QW].ovf || chain[QW].q > QW'(TMAX)) begin
        quo <= TMAX;
      end else begin
        quo <= T_W'(chain[QW].q);
      end
    end else begin
      // floor rounds a negative inexact quotient one further down
      if (chain[QW].ovf || m > (QW+1)'(64'h8000_0000)) begin
        quo <= TMIN;
      end else begin
        quo <= T_W'(T_W'(0) - m[T_W-1:0]);
      end
    end
  end

endmodule

// ===== rtl/swept_aabb_collision_3d_unit.sv =====
// swept 3d box collision test: a new word each cycle, one result per word
// A word is taken on every cycle that start is high (busy is always low) and its result
// appears on the result ports with done high, in input order. It passes a gap stage, a sign
// and range stage, the six quotient chains of one restoring-division cell per quotient bit
// (33 cells), a rounding stage and the output register. Results cannot be held off, so take
// them when done is high. Size registers are written through wr_en, wr_index and wr_data
// only while no word is in flight: a rule for the user that the block does not enforce.
module swept_aabb_collision_3d_unit import sac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] mover_pos_x,
  input  logic signed [POS_W-1:0] mover_pos_y,
  input  logic signed [POS_W-1:0] mover_pos_z,
  input  logic signed [POS_W-1:0] vel_x,
  input  logic signed [POS_W-1:0] vel_y,
  input  logic signed [POS_W-1:0] vel_z,
  input  logic signed [POS_W-1:0] target_pos_x,
  input  logic signed [POS_W-1:0] target_pos_y,
  input  logic signed [POS_W-1:0] target_pos_z,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_index,
  input  logic [SIZE_W-1:0]       wr_data,
  output logic                    done,
  output logic                    hit,
  output logic [ET_W-1:0]         entry_time,
  output logic [1:0]              normal_axis,
  output logic                    normal_negative
);

  logic [SIZE_W-1:0] ms [0:2];
  logic [SIZE_W-1:0] ts [0:2];

  logic signed [POS_W-1:0] mp [0:2];
  logic signed [POS_W-1:0] vv [0:2];
  logic signed [POS_W-1:0] tp [0:2];

  logic signed [GAP_W-1:0] near_gap [0:2];
  logic signed [GAP_W-1:0] far_gap  [0:2];
  logic signed [POS_W-1:0] vel_r    [0:2];
  logic signed [T_W-1:0]   ent_q    [0:2];
  logic signed [T_W-1:0]   ext_q    [0:2];
  logic signed [T_W-1:0]   ent      [0:2];
  logic signed [T_W-1:0]   ext      [0:2];

  side_t side [0:LANE_LAT];

  logic signed [T_W-1:0] t_in, t_out;
  logic                  hit_c;
  logic [1:0]            axis;

  assign busy = 1'b0;

  assign mp[0] = mover_pos_x;
  assign mp[1] = mover_pos_y;
  assign mp[2] = mover_pos_z;
  assign vv[0] = vel_x;
  assign vv[1] = vel_y;
  assign vv[2] = vel_z;
  assign tp[0] = target_pos_x;
  assign tp[1] = target_pos_y;
  assign tp[2] = target_pos_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ms[i] <= SIZE_W'(ONE);
        ts[i] <= SIZE_W'(ONE);
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_MSX: ms[0] <= wr_data;
        REG_MSY: ms[1] <= wr_data;
        REG_MSZ: ms[2] <= wr_data;
        REG_TSX: ts[0] <= wr_data;
        REG_TSY: ts[1] <= wr_data;
        REG_TSZ: ts[2] <= wr_data;
        default: ;
      endcase
    end
  end

  // gap stage
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [GAP_W-1:0] a, b;
      a = GAP_W'(tp[i]) - GAP_W'(mp[i]) - $signed({{(GAP_W-SIZE_W){1'b0}}, ms[i]});
      b = GAP_W'(tp[i]) + $signed({{(GAP_W-SIZE_W){1'b0}}, ts[i]}) - GAP_W'(mp[i]);
      if (vv[i] > 0) begin
        near_gap[i] <= a;
        far_gap[i]  <= b;
      end else begin
        near_gap[i] <= b;
        far_gap[i]  <= a;
      end
      vel_r[i] <= vv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side[0].valid <= 1'b0;
    end else begin
      side[0].valid <= start && !busy;
    end
    for (int i = 0; i < 3; i++) begin
      side[0].pos[i]  <= (vv[i] > 0);
      side[0].zero[i] <= (vv[i] == 0);
    end
  end

  for (genvar k = 0; k < LANE_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[k+1].valid <= 1'b0;
      end else begin
        side[k+1].valid <= side[k].valid;
      end
      side[k+1].pos  <= side[k].pos;
      side[k+1].zero <= side[k].zero;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    sac_div_lane u_entry (
      .clk (clk),
      .num (near_gap[i]),
      .den (vel_r[i]),
      .quo (ent_q[i])
    );
    sac_div_lane u_exit (
      .clk (clk),
      .num (far_gap[i]),
      .den (vel_r[i]),
      .quo (ext_q[i])
    );
    assign ent[i] = side[LANE_LAT].zero[i] ? TMIN : ent_q[i];
    assign ext[i] = side[LANE_LAT].zero[i] ? TMAX : ext_q[i];
  end

  always_comb begin
    t_in = ent[0];
    if (ent[1] > t_in) t_in = ent[1];
    if (ent[2] > t_in) t_in = ent[2];
    t_out = ext[0];
    if (ext[1] < t_out) t_out = ext[1];
    if (ext[2] < t_out) t_out = ext[2];
    hit_c = !(t_in > t_out ||
              (ent[0] < 0 && ent[1] < 0 && ent[2] < 0) ||
              ent[0] > ONE || ent[1] > ONE || ent[2] > ONE);
    // x only on a strict win over both, then y over z
    if (ent[0] > ent[1] && ent[0] > ent[2]) begin
      axis = AXIS_X;
    end else if (ent[1] > ent[2]) begin
      axis = AXIS_Y;
    end else begin
      axis = AXIS_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side[LANE_LAT].valid;
    end
    hit <= hit_c;
    if (hit_c) begin
      entry_time      <= t_in[ET_W-1:0];
      normal_axis     <= axis;
      normal_negative <= side[LANE_LAT].pos[axis];
    end else begin
      entry_time      <= ONE[ET_W-1:0];
      normal_axis     <= AXIS_X;
      normal_negative <= 1'b0;
    end
  end

endmodule

// ===== dv/swept_aabb_collision_3d_checker.sv =====
// checker for the swept box unit: tracks sizes, predicts each result and compares
`timescale 1ns / 100ps
module swept_aabb_collision_3d_checker import sac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [POS_W-1:0] mover_pos_x,
  input  logic signed [POS_W-1:0] mover_pos_y,
  input  logic signed [POS_W-1:0] mover_pos_z,
  input  logic signed [POS_W-1:0] vel_x,
  input  logic signed [POS_W-1:0] vel_y,
  input  logic signed [POS_W-1:0] vel_z,
  input  logic signed [POS_W-1:0] target_pos_x,
  input  logic signed [POS_W-1:0] target_pos_y,
  input  logic signed [POS_W-1:0] target_pos_z,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_index,
  input  logic [SIZE_W-1:0]       wr_data,
  input  logic                    done,
  input  logic                    hit,
  input  logic [ET_W-1:0]         entry_time,
  input  logic [1:0]              normal_axis,
  input  logic                    normal_negative,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic            hit;
    logic [ET_W-1:0] et;
    logic [1:0]      axis;
    logic            neg;
  } sweep_result_t;

  localparam longint T_HI = 64'sd2147483647;
  localparam longint T_LO = -64'sd2147483648;

  logic [SIZE_W-1:0] mover_size [3];
  logic [SIZE_W-1:0] target_size [3];
  sweep_result_t     expected_hits [$];

  // floor(gap * one / vel), saturated to 32 bits
  function automatic longint sweep_time(input longint gap, input longint v);
    longint n, q;
    n = gap * (64'sd1 <<< FRAC_BITS);
    q = n / v;
    if ((n % v) != 0 && ((n < 0) != (v < 0))) q = q - 1;
    if (q > T_HI) q = T_HI;
    if (q < T_LO) q = T_LO;
    return q;
  endfunction

  function automatic sweep_result_t predict_sweep(input longint mp [3], input longint v [3],
                                                  input longint tp [3]);
    longint enter_t [3];
    longint leave_t [3];
    longint near_gap, far_gap, t_in, t_out, one;
    logic [1:0] ax;
    sweep_result_t r;
    one = 64'sd1 <<< FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      if (v[i] > 0) begin
        near_gap = tp[i] - (mp[i] + longint'(mover_size[i]));
        far_gap  = (tp[i] + longint'(target_size[i])) - mp[i];
      end else begin
        near_gap = (tp[i] + longint'(target_size[i])) - mp[i];
        far_gap  = tp[i] - (mp[i] + longint'(mover_size[i]));
      end
      if (v[i] == 0) begin
        enter_t[i] = T_LO;
        leave_t[i] = T_HI;
      end else begin
        enter_t[i] = sweep_time(near_gap, v[i]);
        leave_t[i] = sweep_time(far_gap, v[i]);
      end
    end
    t_in = enter_t[0];
    if (enter_t[1] > t_in) t_in = enter_t[1];
    if (enter_t[2] > t_in) t_in = enter_t[2];
    t_out = leave_t[0];
    if (leave_t[1] < t_out) t_out = leave_t[1];
    if (leave_t[2] < t_out) t_out = leave_t[2];
    if (t_in > t_out || (enter_t[0] < 0 && enter_t[1] < 0 && enter_t[2] < 0) ||
        enter_t[0] > one || enter_t[1] > one || enter_t[2] > one) begin
      r.hit = 1'b0;
      r.et = ET_W'(one);
      r.axis = AXIS_X;
      r.neg = 1'b0;
      return r;
    end
    // x needs a strict win over both, then y over z
    if (enter_t[0] > enter_t[1] && enter_t[0] > enter_t[2]) ax = AXIS_X;
    else if (enter_t[1] > enter_t[2]) ax = AXIS_Y;
    else ax = AXIS_Z;
    r.hit = 1'b1;
    r.et = ET_W'(t_in);
    r.axis = ax;
    r.neg = v[ax] > 0;
    return r;
  endfunction

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    longint mp [3];
    longint v [3];
    longint tp [3];
    sweep_result_t got, want;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        mover_size[i] = 31'd65536;
        target_size[i] = 31'd65536;
      end
      expected_hits.delete();
      errors = 0;
    end else begin
      if (done) begin
        got = {hit, entry_time, normal_axis, normal_negative};
        if (expected_hits.size() == 0) begin
          errors++;
          $display("%0t: unexpected result hit=%0d t=%0d axis=%0d neg=%0d",
                   $time, hit, entry_time, normal_axis, normal_negative);
        end else begin
          want = expected_hits.pop_front();
          if (got.hit !== want.hit || got.et !== want.et || got.axis !== want.axis ||
              got.neg !== want.neg) begin
            errors++;
            $display("%0t: mismatch expected hit=%0d t=%0d axis=%0d neg=%0d", $time,
                     want.hit, want.et, want.axis, want.neg);
            $display("%0t:          actual   hit=%0d t=%0d axis=%0d neg=%0d", $time,
                     got.hit, got.et, got.axis, got.neg);
          end
        end
      end
      if (start && !busy) begin
        mp = '{mover_pos_x, mover_pos_y, mover_pos_z};
        v  = '{vel_x, vel_y, vel_z};
        tp = '{target_pos_x, target_pos_y, target_pos_z};
        expected_hits.push_back(predict_sweep(mp, v, tp));
      end
      if (wr_en) begin
        if (wr_index < 3) mover_size[wr_index] = wr_data;
        else if (wr_index < NREG) target_size[wr_index - 3] = wr_data;
      end
    end
  end

endmodule

// ===== dv/tb_swept_aabb_collision_3d_unit.sv =====
// top of the swept box testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_swept_aabb_collision_3d_unit;
  import sac_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN = LANE_LAT + 15;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [POS_W-1:0] mover_pos_x = '0, mover_pos_y = '0, mover_pos_z = '0;
  logic signed [POS_W-1:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic signed [POS_W-1:0] target_pos_x = '0, target_pos_y = '0, target_pos_z = '0;
  logic wr_en = 1'b0;
  logic [IDX_W-1:0] wr_index = REG_MSX;
  logic [SIZE_W-1:0] wr_data = '0;
  logic done, hit, normal_negative;
  logic [ET_W-1:0] entry_time;
  logic [1:0] normal_axis;
  int errors, pending;
  int cycles = 0;
  int idle_pct = 0;

  always #6 clk = ~clk;

  swept_aabb_collision_3d_unit dut (.*);
  swept_aabb_collision_3d_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_size(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic drain_words();
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // one word, held until accepted, with a random gap ahead of it
  task automatic send_word(input logic [31:0] mx, my, mz, vx, vy, vz, tx, ty, tz);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    {mover_pos_x, mover_pos_y, mover_pos_z} = {mx, my, mz};
    {vel_x, vel_y, vel_z} = {vx, vy, vz};
    {target_pos_x, target_pos_y, target_pos_z} = {tx, ty, tz};
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] near_val(input int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic random_word();
    logic [31:0] t [3];
    logic [31:0] m [3];
    logic [31:0] v [3];
    if ($urandom_range(9) < 2) begin
      send_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
    end else begin
      for (int i = 0; i < 3; i++) begin
        t[i] = near_val(1 << 20);
        m[i] = t[i] + near_val(1 << 19);
        v[i] = ($urandom_range(5) == 0) ? 32'd0 : near_val(1 << 19);
      end
      send_word(m[0], m[1], m[2], v[0], v[1], v[2], t[0], t[1], t[2]);
    end
  endtask

  initial begin
    logic [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // field extremes
    send_word(mx, mx, mx, mx, mx, mx, mx, mx, mx);
    send_word(mn, mn, mn, mn, mn, mn, mn, mn, mn);
    send_word(mn, mn, mn, mx, mx, mx, mx, mx, mx);
    send_word(mx, mx, mx, mn, mn, mn, mn, mn, mn);
    // no motion at all: every axis entry is minus infinity
    send_word(0, 0, 0, 0, 0, 0, 32'h00100000, 0, 0);
    // zero velocity axis with boxes apart on it still passes
    send_word(0, 32'h00500000, 0, 32'h00040000, 0, 0, 32'h00020000, 0, 0);
    // plain hit along x, then -x
    send_word(0, 0, 0, 32'h00020000, 0, 0, 32'h00018000, 0, 0);
    send_word(32'h00030000, 0, 0, 32'hfffe0000, 0, 0, 32'h00010000, 0, 0);
    // entries tied on all axes goes to z, x and y tied goes to y
    send_word(0, 0, 0, 32'h00020000, 32'h00020000, 32'h00020000,
              32'h00020000, 32'h00020000, 32'h00020000);
    send_word(0, 0, 0, 32'h00020000, 32'h00020000, 32'h00010000,
              32'h00020000, 32'h00020000, 32'h00010000);
    // too far: entry beyond one
    send_word(0, 0, 0, 32'h00010000, 0, 0, 32'h00050000, 0, 0);
    // moving apart: entry after exit
    send_word(0, 0, 0, 32'hffff0000, 32'h00010000, 0, 32'h00030000, 0, 0);
    // entry exactly one, and just above one that floors to one
    send_word(0, 0, 0, 32'h00010000, 0, 0, 32'h00020000, 0, 0);
    send_word(0, 0, 0, 32'h00030000, 0, 0, 32'h00040001, 0, 0);
    // already overlapping: all entries negative
    send_word(0, 0, 0, 32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 0);
    // saturation with a tiny velocity
    send_word(0, 0, 0, 32'd1, 32'hffffffff, 32'd1, 32'h10000000, 32'h00010000, 0);
    @(negedge clk);
    start = 1'b0;
    drain_words();

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 13 : (ph < 4) ? 75 : 0;
      for (int r = 0; r < NREG; r++) begin
        case (ph)
          0: write_size(IDX_W'(r), 31'd65536);
          1: write_size(IDX_W'(r), '0);
          2: write_size(IDX_W'(r), {SIZE_W{1'b1}});
          3: write_size(IDX_W'(r), (r % 2) ? '0 : {SIZE_W{1'b1}});
          default: write_size(IDX_W'(r), SIZE_W'($urandom_range(1 << 20)));
        endcase
      end
      repeat (135) random_word();
      @(negedge clk);
      start = 1'b0;
      drain_words();
    end

    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sac_pkg.sv
rtl/sac_div_cell.sv
rtl/sac_div_lane.sv
rtl/swept_aabb_collision_3d_unit.sv
dv/swept_aabb_collision_3d_checker.sv
dv/tb_swept_aabb_collision_3d_unit.sv
